@@ rtl/bgdc_pkg.sv @@
`timescale 1ns / 1ps

package bgdc_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;

  localparam logic [CfgIndexWidth-1:0] REG_DEBOUNCE_TIME       = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_DOUBLE_CLICK_WINDOW = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_LONG_PRESS_TIME     = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_REPEAT_PERIOD       = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_COMMON_ANODE        = 3'd4;

  // Reset values of the registers
  localparam logic [15:0] DEBOUNCE_TIME_RESET       = 16'd25;
  localparam logic [15:0] DOUBLE_CLICK_WINDOW_RESET = 16'd350;
  localparam logic [15:0] LONG_PRESS_TIME_RESET     = 16'd800;
  localparam logic [15:0] REPEAT_PERIOD_RESET       = 16'd500;

  localparam logic [3:0] DIGIT_MAX = 4'd9;

  typedef struct packed {
    logic [31:0] time_ms;
    logic        button_level;
  } sample_t;

  typedef struct packed {
    logic [3:0] digit;
    logic [6:0] segments;
  } result_t;

  typedef struct packed {
    logic [15:0] debounce_time;
    logic [15:0] double_click_window;
    logic [15:0] long_press_time;
    logic [15:0] repeat_period;
    logic        common_anode;
  } cfg_t;

  // Wrap 9 -> 0
  function automatic logic [3:0] bump_up(input logic [3:0] value);
    bump_up = (value >= DIGIT_MAX) ? 4'd0 : value + 4'd1;
  endfunction

  // Wrap 0 -> 9
  function automatic logic [3:0] bump_down(input logic [3:0] value);
    bump_down = (value == 4'd0 || value > DIGIT_MAX) ? DIGIT_MAX : value - 4'd1;
  endfunction

  // Segments a..g in bits 0..6, common cathode polarity
  function automatic logic [6:0] seg_pattern(input logic [3:0] value);
    case (value)
      4'd0:    seg_pattern = 7'h3F;
      4'd1:    seg_pattern = 7'h06;
      4'd2:    seg_pattern = 7'h5B;
      4'd3:    seg_pattern = 7'h4F;
      4'd4:    seg_pattern = 7'h66;
      4'd5:    seg_pattern = 7'h6D;
      4'd6:    seg_pattern = 7'h7D;
      4'd7:    seg_pattern = 7'h07;
      4'd8:    seg_pattern = 7'h7F;
      4'd9:    seg_pattern = 7'h6F;
      default: seg_pattern = 7'h3F;
    endcase
  endfunction

endpackage

@@ rtl/bgdc_cfg.sv @@
`timescale 1ns / 1ps

module bgdc_cfg
  import bgdc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  output cfg_t                     cfg
);

  // Decode writes into the register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time       <= DEBOUNCE_TIME_RESET;
      cfg.double_click_window <= DOUBLE_CLICK_WINDOW_RESET;
      cfg.long_press_time     <= LONG_PRESS_TIME_RESET;
      cfg.repeat_period       <= REPEAT_PERIOD_RESET;
      cfg.common_anode        <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEBOUNCE_TIME:       cfg.debounce_time       <= cfg_data;
        REG_DOUBLE_CLICK_WINDOW: cfg.double_click_window <= cfg_data;
        REG_LONG_PRESS_TIME:     cfg.long_press_time     <= cfg_data;
        REG_REPEAT_PERIOD:       cfg.repeat_period       <= cfg_data;
        REG_COMMON_ANODE:        cfg.common_anode        <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/bgdc_step.sv @@
`timescale 1ns / 1ps

module bgdc_step
  import bgdc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    enable,
  input  sample_t sample,
  input  cfg_t    cfg,
  output result_t result
);

  logic        previous_raw;
  logic        stable_pressed;
  logic [31:0] last_change_time;
  logic [31:0] press_start_time;
  logic [31:0] click_release_time;
  logic [31:0] last_step_time;
  logic        click_pending;
  logic        long_press_active;
  logic [3:0]  count_value;

  logic        stable_pressed_next;
  logic [31:0] last_change_time_next;
  logic [31:0] press_start_time_next;
  logic [31:0] click_release_time_next;
  logic [31:0] last_step_time_next;
  logic        click_pending_next;
  logic        long_press_active_next;
  logic [3:0]  count_value_next;

  logic        raw;
  logic [31:0] now;
  logic [31:0] since_change;
  logic [31:0] since_release;
  logic [31:0] since_press;
  logic [31:0] since_step;
  logic [31:0] since_release_end;
  logic [6:0]  seg;

  // Debounce, decode gestures and update the counter for one sample
  always_comb begin
    now = sample.time_ms;
    raw = ~sample.button_level;

    stable_pressed_next     = stable_pressed;
    press_start_time_next   = press_start_time;
    click_release_time_next = click_release_time;
    last_step_time_next     = last_step_time;
    click_pending_next      = click_pending;
    long_press_active_next  = long_press_active;
    count_value_next        = count_value;

    // Restart the stability timer on any raw change
    last_change_time_next = (raw != previous_raw) ? now : last_change_time;
    since_change  = now - last_change_time_next;
    since_release = now - click_release_time;

    // Accept a debounced edge
    if (since_change >= {16'd0, cfg.debounce_time} && raw != stable_pressed) begin
      stable_pressed_next = raw;
      if (raw) begin
        press_start_time_next  = now;
        long_press_active_next = 1'b0;
        if (click_pending && since_release > {16'd0, cfg.double_click_window}) begin
          count_value_next   = bump_up(count_value_next);
          click_pending_next = 1'b0;
        end
      end else if (!long_press_active) begin
        if (click_pending) begin
          count_value_next   = bump_down(count_value_next);
          click_pending_next = 1'b0;
        end else begin
          click_pending_next      = 1'b1;
          click_release_time_next = now;
        end
      end
    end

    // Recognize a long press, then auto-repeat
    since_press = now - press_start_time_next;
    since_step  = now - last_step_time;
    if (stable_pressed_next) begin
      if (!long_press_active_next && since_press >= {16'd0, cfg.long_press_time}) begin
        long_press_active_next = 1'b1;
        if (click_pending_next) begin
          count_value_next   = bump_up(count_value_next);
          click_pending_next = 1'b0;
        end
        count_value_next    = bump_up(count_value_next);
        last_step_time_next = now;
      end else if (long_press_active_next && since_step >= {16'd0, cfg.repeat_period}) begin
        count_value_next    = bump_up(count_value_next);
        last_step_time_next = now;
      end
    end

    // Commit a single click once the window has closed
    since_release_end = now - click_release_time_next;
    if (click_pending_next && !stable_pressed_next &&
        since_release_end >= {16'd0, cfg.double_click_window}) begin
      count_value_next   = bump_up(count_value_next);
      click_pending_next = 1'b0;
    end

    seg = seg_pattern(count_value_next);
    result.digit    = count_value_next;
    result.segments = cfg.common_anode ? ~seg : seg;
  end

  // Hold gesture state between samples
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_raw       <= 1'b0;
      stable_pressed     <= 1'b0;
      last_change_time   <= 32'd0;
      press_start_time   <= 32'd0;
      click_release_time <= 32'd0;
      last_step_time     <= 32'd0;
      click_pending      <= 1'b0;
      long_press_active  <= 1'b0;
      count_value        <= 4'd0;
    end else if (enable) begin
      previous_raw       <= raw;
      stable_pressed     <= stable_pressed_next;
      last_change_time   <= last_change_time_next;
      press_start_time   <= press_start_time_next;
      click_release_time <= click_release_time_next;
      last_step_time     <= last_step_time_next;
      click_pending      <= click_pending_next;
      long_press_active  <= long_press_active_next;
      count_value        <= count_value_next;
    end
  end

endmodule

@@ rtl/button_gesture_digit_counter.sv @@
`timescale 1ns / 1ps

// Button gesture digit counter.
// Sample channel (sample_valid / sample_stall / sample): one poll sample per
// beat, a millisecond timestamp and the raw active-low button level.
// Result channel (result_valid / result_stall / result): one beat per sample,
// the 0..9 counter after that sample and its seven-segment pattern.
// Configuration: cfg_write with cfg_index and cfg_data sets one register per
// clock; write only while no sample is in flight.
// Path: an accepted sample sits in the sample register, is processed by the
// gesture step and is loaded into the result register, which raises
// result_valid; while the result stalls, the sample waits in its register.
// Throughput: one sample per cycle unless the result stalls; the whole gesture
// step is a single pass of logic between the sample and result registers.
// Reset: counter at 0, button released, timers at 0, registers at their
// defaults; both valids low.
// When the receiver stalls, the result holds and one more sample is taken
// into the sample register; after that sample_stall rises until the result
// beat leaves.
module button_gesture_digit_counter
  import bgdc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sample_valid,
  output logic                     sample_stall,
  input  sample_t                  sample,
  output logic                     result_valid,
  input  logic                     result_stall,
  output result_t                  result,
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data
);

  cfg_t    cfg;
  sample_t sample_q;
  logic    sample_q_valid;
  logic    out_free;
  logic    fire;
  logic    sample_take;
  result_t step_result;

  assign out_free     = !result_valid || !result_stall;
  assign fire         = sample_q_valid && out_free;
  assign sample_stall = sample_q_valid && !out_free;
  assign sample_take  = sample_valid && !sample_stall;

  bgdc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bgdc_step u_step (
    .clk    (clk),
    .rst    (rst),
    .enable (fire),
    .sample (sample_q),
    .cfg    (cfg),
    .result (step_result)
  );

  // Sample register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_q_valid <= 1'b0;
    end else if (sample_take) begin
      sample_q_valid <= 1'b1;
    end else if (fire) begin
      sample_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_take) begin
      sample_q <= sample;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= step_result;
    end
  end

  // Checks
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.digit <= DIGIT_MAX)
    else $error("digit out of range");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> sample_q_valid && result_valid)
    else $error("sample stalled with room in the pipeline");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> result_valid)
    else $error("processed sample produced no result beat");

  a_take_fills_register: assert property (@(posedge clk) disable iff (rst)
    sample_take |=> sample_q_valid)
    else $error("accepted sample lost");

endmodule

@@ tb/button_gesture_digit_counter_test.sv @@
`timescale 1ns / 1ps

module button_gesture_digit_counter_test;
  import bgdc_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseItems    = 200;
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned IdlePercent   = 12;
  localparam int unsigned SettleCycles  = 4;

  // Common cathode patterns for 0..9, segments a..g in bits 0..6
  localparam logic [6:0] DIGIT_FONT [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  typedef struct packed {
    logic [31:0] stamp;
    logic        level;
    logic        typed;
    result_t     want;
  } script_row_t;

  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     sample_valid = 1'b0;
  logic                     sample_stall;
  sample_t                  sample_beat  = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  result_t                  result_beat;
  logic                     cfg_write    = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index    = '0;
  logic [CfgDataWidth-1:0]  cfg_data     = '0;

  // Hand-written expectation travels with the beat it belongs to
  logic    beat_typed = 1'b0;
  result_t beat_want  = '0;
  logic    steady     = 1'b0;

  // Gesture decoder mirror
  cfg_t        cfg_now;
  logic        raw_prev;
  logic        held;
  logic        click_waiting;
  logic        long_hold;
  logic [31:0] changed_at;
  logic [31:0] pressed_at;
  logic [31:0] released_at;
  logic [31:0] stepped_at;
  logic [3:0]  digit_now;

  logic [31:0] clock_now = '0;
  result_t     pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned sent_items     = 0;
  script_row_t script [26];

  button_gesture_digit_counter uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_beat),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [3:0] digit_up(input logic [3:0] v);
    return (v >= DIGIT_MAX) ? 4'd0 : v + 4'd1;
  endfunction

  function automatic logic [3:0] digit_down(input logic [3:0] v);
    return (v == 4'd0 || v > DIGIT_MAX) ? DIGIT_MAX : v - 4'd1;
  endfunction

  task automatic clear_model();
    cfg_now = '{debounce_time: DEBOUNCE_TIME_RESET,
                double_click_window: DOUBLE_CLICK_WINDOW_RESET,
                long_press_time: LONG_PRESS_TIME_RESET,
                repeat_period: REPEAT_PERIOD_RESET,
                common_anode: 1'b0};
    raw_prev      = 1'b0;
    held          = 1'b0;
    click_waiting = 1'b0;
    long_hold     = 1'b0;
    changed_at    = '0;
    pressed_at    = '0;
    released_at   = '0;
    stepped_at    = '0;
    digit_now     = '0;
  endtask

  // Advance the decoder by one poll sample and return the display it shows
  function automatic result_t step_gesture(input sample_t s);
    logic [31:0] now_ms;
    logic [31:0] gap;
    logic        pressed_raw;
    result_t     r;
    now_ms      = s.time_ms;
    pressed_raw = ~s.button_level;
    if (pressed_raw != raw_prev) changed_at = now_ms;

    // Debounce: accept the raw level once it has been stable long enough
    gap = now_ms - changed_at;
    if (gap >= {16'd0, cfg_now.debounce_time} && pressed_raw != held) begin
      held = pressed_raw;
      if (held) begin
        pressed_at = now_ms;
        long_hold  = 1'b0;
        gap = now_ms - released_at;
        if (click_waiting && gap > {16'd0, cfg_now.double_click_window}) begin
          digit_now     = digit_up(digit_now);
          click_waiting = 1'b0;
        end
      end else if (!long_hold) begin
        if (click_waiting) begin
          digit_now     = digit_down(digit_now);
          click_waiting = 1'b0;
        end else begin
          click_waiting = 1'b1;
          released_at   = now_ms;
        end
      end
    end
    raw_prev = pressed_raw;

    // Long press recognition and auto-repeat
    if (held) begin
      gap = now_ms - pressed_at;
      if (!long_hold && gap >= {16'd0, cfg_now.long_press_time}) begin
        long_hold = 1'b1;
        if (click_waiting) begin
          digit_now     = digit_up(digit_now);
          click_waiting = 1'b0;
        end
        digit_now  = digit_up(digit_now);
        stepped_at = now_ms;
      end else if (long_hold && (now_ms - stepped_at) >= {16'd0, cfg_now.repeat_period}) begin
        digit_now  = digit_up(digit_now);
        stepped_at = now_ms;
      end
    end

    // Commit a single click once its window has run out
    gap = now_ms - released_at;
    if (click_waiting && !held && gap >= {16'd0, cfg_now.double_click_window}) begin
      digit_now     = digit_up(digit_now);
      click_waiting = 1'b0;
    end

    r.digit    = digit_now;
    r.segments = cfg_now.common_anode ? ~DIGIT_FONT[digit_now] : DIGIT_FONT[digit_now];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    end
  endtask

  // Random result-side stall
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= !steady && ($urandom_range(0, 99) < IdlePercent);
    end
  end

  // Predict on every accepted sample beat, check every accepted result beat
  always @(posedge clk) begin : watch_ports
    result_t predicted;
    result_t oldest;
    logic    moved;
    if (!rst) begin
      moved = 1'b0;
      if (sample_valid && !sample_stall) begin
        predicted = step_gesture(sample_beat);
        pending_results.push_back(beat_typed ? beat_want : predicted);
        moved = 1'b1;
      end
      if (result_valid && !result_stall) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          flag_mismatch("unexpected result beat, digit", 0, 32'(result_beat.digit));
        end else begin
          oldest = pending_results.pop_front();
          if (result_beat.digit !== oldest.digit) begin
            flag_mismatch("digit", 32'(oldest.digit), 32'(result_beat.digit));
          end
          if (result_beat.segments !== oldest.segments) begin
            flag_mismatch("segments", 32'(oldest.segments), 32'(result_beat.segments));
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Offer one sample beat and hold it until taken
  task automatic send_sample(input logic level, input logic [31:0] stamp,
                             input logic typed, input result_t want);
    while (!steady && $urandom_range(0, 99) < IdlePercent) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_beat  <= '{time_ms: stamp, button_level: level};
    beat_typed   <= typed;
    beat_want    <= want;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic tick_level(input logic level, input int unsigned dt);
    clock_now = clock_now + dt;
    send_sample(level, clock_now, 1'b0, '0);
  endtask

  // Change the raw level, then poll it a few times over span ms
  task automatic hold_level(input logic level, input int unsigned span);
    int unsigned polls;
    int unsigned k;
    int unsigned done;
    int unsigned step;
    tick_level(level, $urandom_range(0, 3));
    polls = $urandom_range(1, 6);
    done  = 0;
    for (k = 1; k <= polls; k++) begin
      step = (k == polls) ? span - done : $urandom_range(0, (span - done) / 2);
      tick_level(level, step);
      done += step;
    end
  endtask

  // Land on, just past, just short of, or around a threshold
  function automatic int unsigned pick_span(input int unsigned mark);
    case ($urandom_range(0, 3))
      0:       return mark;
      1:       return mark + 1;
      2:       return (mark == 0) ? 0 : mark - 1;
      default: return $urandom_range(0, 2 * mark + 2);
    endcase
  endfunction

  function automatic int unsigned short_hold(input int unsigned lp);
    return (lp == 0) ? 0 : $urandom_range(0, lp - 1);
  endfunction

  task automatic play_gesture();
    int unsigned db;
    int unsigned win;
    int unsigned lp;
    int unsigned rp;
    int unsigned n;
    int unsigned k;
    int unsigned jump;
    db  = 32'(cfg_now.debounce_time);
    win = 32'(cfg_now.double_click_window);
    lp  = 32'(cfg_now.long_press_time);
    rp  = 32'(cfg_now.repeat_period);
    case ($urandom_range(0, 9))
      0, 1: begin
        // single click
        hold_level(1'b0, db + short_hold(lp));
        hold_level(1'b1, db + pick_span(win));
      end
      2, 3: begin
        // double click, second press near the window edge
        hold_level(1'b0, db + short_hold(lp));
        hold_level(1'b1, db + pick_span(win));
        hold_level(1'b0, db + short_hold(lp));
        hold_level(1'b1, db + pick_span(win));
      end
      4, 5: begin
        // long press with some auto-repeats
        hold_level(1'b0, db + pick_span(lp) + $urandom_range(0, 3) * rp
                         + $urandom_range(0, rp));
        hold_level(1'b1, db + pick_span(win));
      end
      6, 7: begin
        // click, then a press held into a long press
        hold_level(1'b0, db + short_hold(lp));
        hold_level(1'b1, db + $urandom_range(0, win));
        hold_level(1'b0, db + pick_span(lp) + $urandom_range(0, rp));
        hold_level(1'b1, db + pick_span(win));
      end
      8: begin
        // contact bounce with gaps around and below the debounce time
        n = $urandom_range(2, 6);
        for (k = 0; k < n; k++) tick_level(k[0], $urandom_range(0, db + 1));
      end
      default: begin
        // arbitrary levels and time jumps, wrap included
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
          case ($urandom_range(0, 2))
            0:       jump = 0;
            1:       jump = $urandom_range(0, 70000);
            default: jump = $urandom;
          endcase
          tick_level($urandom_range(0, 1) == 1, jump);
        end
      end
    endcase
  endtask

  // Stop offering beats and let everything in flight come out
  task automatic drain();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_DEBOUNCE_TIME:       cfg_now.debounce_time       = value;
      REG_DOUBLE_CLICK_WINDOW: cfg_now.double_click_window = value;
      REG_LONG_PRESS_TIME:     cfg_now.long_press_time     = value;
      REG_REPEAT_PERIOD:       cfg_now.repeat_period       = value;
      REG_COMMON_ANODE:        cfg_now.common_anode        = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input cfg_t c);
    logic [CfgDataWidth-1:0] spare;
    spare = CfgDataWidth'($urandom);
    write_reg(REG_DEBOUNCE_TIME, c.debounce_time);
    write_reg(REG_DOUBLE_CLICK_WINDOW, c.double_click_window);
    write_reg(REG_LONG_PRESS_TIME, c.long_press_time);
    write_reg(REG_REPEAT_PERIOD, c.repeat_period);
    // upper bits of the polarity word carry junk
    write_reg(REG_COMMON_ANODE, {spare[CfgDataWidth-1:1], c.common_anode});
    cfg_write <= 1'b0;
  endtask

  function automatic logic [15:0] maybe_wide(input int unsigned hi);
    return 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(0, hi));
  endfunction

  function automatic cfg_t pick_settings(input int unsigned phase);
    cfg_t c;
    case (phase)
      0: c = '{16'd0, 16'd0, 16'd0, 16'd0, 1'b1};
      1: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0};
      2: c = '{DEBOUNCE_TIME_RESET, DOUBLE_CLICK_WINDOW_RESET, LONG_PRESS_TIME_RESET,
               REPEAT_PERIOD_RESET, 1'b1};
      3: c = '{16'($urandom_range(0, 8)), 16'($urandom_range(0, 40)),
               16'($urandom_range(0, 60)), 16'($urandom_range(0, 20)),
               $urandom_range(0, 1) == 1};
      default: c = '{maybe_wide(100), maybe_wide(1000), maybe_wide(2000),
                     maybe_wide(1000), $urandom_range(0, 1) == 1};
    endcase
    return c;
  endfunction

  initial begin : run_stimulus
    int unsigned row;
    int unsigned phase;
    clear_model();
    // double click with wrap to 9, late second press with wrap to 0,
    // long press with repeat, click followed by a held press
    script = '{
      '{32'd0,    1'b1, 1'b1, {4'd0, 7'h3F}},
      '{32'd100,  1'b0, 1'b0, 11'd0},
      '{32'd130,  1'b0, 1'b0, 11'd0},
      '{32'd200,  1'b1, 1'b0, 11'd0},
      '{32'd230,  1'b1, 1'b0, 11'd0},
      '{32'd300,  1'b0, 1'b0, 11'd0},
      '{32'd330,  1'b0, 1'b0, 11'd0},
      '{32'd400,  1'b1, 1'b0, 11'd0},
      '{32'd430,  1'b1, 1'b1, {4'd9, 7'h6F}},
      '{32'd500,  1'b0, 1'b0, 11'd0},
      '{32'd530,  1'b0, 1'b0, 11'd0},
      '{32'd600,  1'b1, 1'b0, 11'd0},
      '{32'd630,  1'b1, 1'b0, 11'd0},
      '{32'd900,  1'b0, 1'b0, 11'd0},
      '{32'd1000, 1'b0, 1'b1, {4'd0, 7'h3F}},
      '{32'd1800, 1'b0, 1'b0, 11'd0},
      '{32'd2300, 1'b0, 1'b0, 11'd0},
      '{32'd2400, 1'b1, 1'b0, 11'd0},
      '{32'd2425, 1'b1, 1'b0, 11'd0},
      '{32'd2500, 1'b0, 1'b0, 11'd0},
      '{32'd2525, 1'b0, 1'b0, 11'd0},
      '{32'd2600, 1'b1, 1'b0, 11'd0},
      '{32'd2625, 1'b1, 1'b0, 11'd0},
      '{32'd2700, 1'b0, 1'b0, 11'd0},
      '{32'd2725, 1'b0, 1'b0, 11'd0},
      '{32'd3525, 1'b0, 1'b1, {4'd4, 7'h66}}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed script at reset settings
    for (row = 0; row < $size(script); row++) begin
      clock_now = script[row].stamp;
      send_sample(script[row].level, script[row].stamp, script[row].typed,
                  script[row].want);
    end

    // Random gestures under several settings, one stretch without idling
    for (phase = 0; phase < PhaseCount; phase++) begin
      drain();
      apply_settings(pick_settings(phase));
      steady     = (phase == 3);
      clock_now  = (phase == 0) ? 32'hFFFF_FF00 : $urandom;
      sent_items = 0;
      while (sent_items < PhaseItems) play_gesture();
    end

    drain();
    mismatch_count += pending_results.size();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
